FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the merge grouper RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every cycle out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent holds on the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/kmg_pkg.sv
// Package for the k-way record merge grouper: sizes, status codes and
// the result and compare-tree node types. No dependencies.
`default_nettype none

package kmg_pkg;

  localparam int WAYS        = 8;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(WAYS);
  localparam int CNT_W       = $clog2(WAYS + 1);
  localparam int CFG_W       = 4;
  localparam int TREE_LEAVES = 1 << IDX_W;
  localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

  localparam logic [1:0] ST_RECORD = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] term;
    logic [KEY_W-1:0] doc;
    logic             new_term;
    logic [IDX_W-1:0] refill;
  } res_t;

  typedef struct packed {
    logic               vld;
    logic [IDX_W-1:0]   idx;
    logic [2*KEY_W-1:0] key;
  } node_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kmg_min_tree.sv
// Compare tree that picks the smallest valid head by (term, doc, index).
// Uses kmg_pkg for sizes and the node type.
`default_nettype none

module kmg_min_tree (
  input  wire logic [kmg_pkg::WAYS-1:0]  leaf_vld,
  input  wire logic [kmg_pkg::KEY_W-1:0] leaf_term [kmg_pkg::WAYS],
  input  wire logic [kmg_pkg::KEY_W-1:0] leaf_doc  [kmg_pkg::WAYS],
  output logic                           found,
  output logic [kmg_pkg::IDX_W-1:0]      best_idx,
  output logic [kmg_pkg::KEY_W-1:0]      best_term,
  output logic [kmg_pkg::KEY_W-1:0]      best_doc
);

  kmg_pkg::node_t nodes [kmg_pkg::TREE_NODES];

  for (genvar i = 0; i < kmg_pkg::TREE_LEAVES; i++) begin : g_leaf
    if (i < kmg_pkg::WAYS) begin : g_real
      assign nodes[kmg_pkg::TREE_LEAVES-1+i] =
        '{vld: leaf_vld[i], idx: kmg_pkg::IDX_W'(i), key: {leaf_term[i], leaf_doc[i]}};
    end else begin : g_pad
      assign nodes[kmg_pkg::TREE_LEAVES-1+i] = '0;
    end
  end

  // left child holds lower indices: it wins ties
  for (genvar j = 0; j < kmg_pkg::TREE_LEAVES - 1; j++) begin : g_node
    logic take_right;
    assign take_right = nodes[2*j+2].vld &&
                        (!nodes[2*j+1].vld || (nodes[2*j+2].key < nodes[2*j+1].key));
    assign nodes[j] = take_right ? nodes[2*j+2] : nodes[2*j+1];
  end

  assign found     = nodes[0].vld;
  assign best_idx  = nodes[0].idx;
  assign best_term = nodes[0].key[2*kmg_pkg::KEY_W-1:kmg_pkg::KEY_W];
  assign best_doc  = nodes[0].key[kmg_pkg::KEY_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/kmg_core.sv
// Input register, head slots and merge decision for the merge grouper.
// Uses kmg_pkg, kmg_min_tree and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kmg_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [kmg_pkg::CFG_W-1:0]    active_cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [kmg_pkg::IDX_W-1:0]    in_stream_index,
  input  wire logic                         in_end_of_stream,
  input  wire logic [kmg_pkg::KEY_W-1:0]    in_term_id,
  input  wire logic [kmg_pkg::KEY_W-1:0]    in_doc_id,
  input  wire logic                         res_free,
  output logic                              res_valid,
  output kmg_pkg::res_t                     res
);

  logic                      in_v_r;
  logic [kmg_pkg::IDX_W-1:0] in_idx_r;
  logic                      in_eos_r;
  logic [kmg_pkg::KEY_W-1:0] in_term_r;
  logic [kmg_pkg::KEY_W-1:0] in_doc_r;

  logic [kmg_pkg::WAYS-1:0]  head_full_r, head_full_nxt;
  logic [kmg_pkg::WAYS-1:0]  run_ended_r, run_ended_nxt;
  logic [kmg_pkg::KEY_W-1:0] head_term_r [kmg_pkg::WAYS];
  logic [kmg_pkg::KEY_W-1:0] head_doc_r  [kmg_pkg::WAYS];
  logic [kmg_pkg::KEY_W-1:0] prev_term_r, prev_term_nxt;
  logic                      have_prev_r, have_prev_nxt;

  logic [kmg_pkg::CNT_W-1:0] n_act;
  logic [kmg_pkg::WAYS-1:0]  act;
  logic                      fire, err, wr_head, ready_all, emit;
  logic [kmg_pkg::WAYS-1:0]  full_upd, ended_upd;
  logic [kmg_pkg::KEY_W-1:0] leaf_term [kmg_pkg::WAYS];
  logic [kmg_pkg::KEY_W-1:0] leaf_doc  [kmg_pkg::WAYS];
  logic                      found;
  logic [kmg_pkg::IDX_W-1:0] best_idx;
  logic [kmg_pkg::KEY_W-1:0] best_term, best_doc;

  assign fire     = in_v_r && res_free;
  assign in_ready = !in_v_r || fire;

  always_comb begin
    if (active_cfg == '0) begin
      n_act = kmg_pkg::CNT_W'(1);
    end else if (kmg_pkg::CNT_W'(active_cfg) > kmg_pkg::CNT_W'(kmg_pkg::WAYS)) begin
      n_act = kmg_pkg::CNT_W'(kmg_pkg::WAYS);
    end else begin
      n_act = kmg_pkg::CNT_W'(active_cfg);
    end
  end

  always_comb begin
    for (int i = 0; i < kmg_pkg::WAYS; i++) begin
      act[i] = kmg_pkg::CNT_W'(i) < n_act;
    end
  end

  assign err = (kmg_pkg::CNT_W'(in_idx_r) >= n_act) || head_full_r[in_idx_r] ||
               run_ended_r[in_idx_r];
  assign wr_head = !err && !in_eos_r;

  always_comb begin
    full_upd  = head_full_r;
    ended_upd = run_ended_r;
    if (!err) begin
      if (in_eos_r) begin
        ended_upd[in_idx_r] = 1'b1;
      end else begin
        full_upd[in_idx_r] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < kmg_pkg::WAYS; i++) begin
      if (wr_head && (in_idx_r == kmg_pkg::IDX_W'(i))) begin
        leaf_term[i] = in_term_r;
        leaf_doc[i]  = in_doc_r;
      end else begin
        leaf_term[i] = head_term_r[i];
        leaf_doc[i]  = head_doc_r[i];
      end
    end
  end

  kmg_min_tree u_tree (
    .leaf_vld  (full_upd & act),
    .leaf_term (leaf_term),
    .leaf_doc  (leaf_doc),
    .found     (found),
    .best_idx  (best_idx),
    .best_term (best_term),
    .best_doc  (best_doc)
  );

  assign ready_all = &(full_upd | ended_upd | ~act);
  assign emit      = !err && ready_all && found;
  assign res_valid = fire && (err || ready_all);

  always_comb begin
    res = '0;
    if (err) begin
      res.status = kmg_pkg::ST_ERROR;
    end else if (!found) begin
      res.status = kmg_pkg::ST_DONE;
    end else begin
      res.status   = kmg_pkg::ST_RECORD;
      res.term     = best_term;
      res.doc      = best_doc;
      res.new_term = !have_prev_r || (best_term != prev_term_r);
      res.refill   = best_idx;
    end
  end

  always_comb begin
    head_full_nxt = head_full_r;
    run_ended_nxt = run_ended_r;
    prev_term_nxt = prev_term_r;
    have_prev_nxt = have_prev_r;
    if (fire) begin
      head_full_nxt = full_upd;
      run_ended_nxt = ended_upd;
      if (emit) begin
        head_full_nxt[best_idx] = 1'b0;
        prev_term_nxt           = best_term;
        have_prev_nxt           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      head_full_r <= '0;
      run_ended_r <= '0;
      prev_term_r <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      head_full_r <= head_full_nxt;
      run_ended_r <= run_ended_nxt;
      prev_term_r <= prev_term_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_idx_r  <= in_stream_index;
      in_eos_r  <= in_end_of_stream;
      in_term_r <= in_term_id;
      in_doc_r  <= in_doc_id;
    end
    if (fire && wr_head) begin
      head_term_r[in_idx_r] <= in_term_r;
      head_doc_r[in_idx_r]  <= in_doc_r;
    end
  end

  `ASSERT_ALWAYS(a_full_ended_excl, (head_full_r & run_ended_r) == '0)
  `ASSERT_NEXT(a_emit_clears_slot, fire && emit, !head_full_r[$past(best_idx)])
  `ASSERT_NEXT(a_err_keeps_slots, fire && err, $stable(head_full_r) && $stable(run_ended_r))

endmodule

`default_nettype wire

FILE: hw/rtl/kway_record_merge_grouper_unit.sv
// K-way record merge grouper: configuration register, core and result register.
// Uses kmg_pkg and kmg_core.
// Usage:
//   cfg_we/cfg_wdata write active_streams (number of runs, saturated to 1..8);
//   write only while the block is idle. Reset value is 8.
//   Input channel (in_valid/in_ready): each transaction delivers the next
//   record of one run, or that run's end mark, into its head slot.
//   Result channel (out_valid/out_ready): status 0 carries the smallest head
//   with its new-term flag and the run to refill, status 1 reports that all
//   runs ended, status 2 flags a dropped transaction for a bad slot.
//   Apart from a dropped one, a transaction that leaves some active run
//   without head or end mark produces no result.
// Timing:
//   A transaction lands in the input register; once the result register is
//   free, the merge decision (eight-way compare tree over the head registers)
//   loads the result register and raises out_valid when it yields a result.
//   Throughput is one transaction per cycle while out_ready stays high.
//   When the receiver stalls, the result register holds and the input
//   register fills, then in_ready drops until the result is taken.
// Reset: synchronous, active low; clears all slots, flags and pending data.
`default_nettype none

module kway_record_merge_grouper_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [kmg_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [kmg_pkg::IDX_W-1:0]   in_stream_index,
  input  wire logic                        in_end_of_stream,
  input  wire logic [kmg_pkg::KEY_W-1:0]   in_term_id,
  input  wire logic [kmg_pkg::KEY_W-1:0]   in_doc_id,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [kmg_pkg::KEY_W-1:0]        out_term,
  output logic [kmg_pkg::KEY_W-1:0]        out_doc,
  output logic                             out_new_term,
  output logic [kmg_pkg::IDX_W-1:0]        out_refill_stream
);

  logic [kmg_pkg::CFG_W-1:0] active_r;
  logic                      out_valid_r;
  kmg_pkg::res_t             out_res_r;
  kmg_pkg::res_t             res;
  logic                      res_valid, res_free;

  assign res_free = !out_valid_r || out_ready;

  kmg_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .active_cfg       (active_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_index  (in_stream_index),
    .in_end_of_stream (in_end_of_stream),
    .in_term_id       (in_term_id),
    .in_doc_id        (in_doc_id),
    .res_free         (res_free),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= kmg_pkg::CFG_W'(kmg_pkg::WAYS);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (res_free) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_term          = out_res_r.term;
  assign out_doc           = out_res_r.doc;
  assign out_new_term      = out_res_r.new_term;
  assign out_refill_stream = out_res_r.refill;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Testbench for kway_record_merge_grouper_unit: a directed table, then random merge
// traffic checked against a behavioral merge predictor under varied idling.
// Depends on kmg_pkg and the unit RTL.
module testbench;

  typedef struct packed {
    logic          is_cfg;
    logic [3:0]    cfg_val;
    logic [2:0]    run;
    logic          eos;
    logic [31:0]   term;
    logic [31:0]   doc;
    logic          typed;
    logic          has_res;
    kmg_pkg::res_t want;
  } plan_row_t;

  localparam kmg_pkg::res_t NO_RES   = '0;
  localparam kmg_pkg::res_t ERR_RES  = '{kmg_pkg::ST_ERROR, 32'h0, 32'h0, 1'b0, 3'd0};
  localparam kmg_pkg::res_t DONE_RES = '{kmg_pkg::ST_DONE, 32'h0, 32'h0, 1'b0, 3'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_stream_index = 3'd0;
  logic        in_end_of_stream = 1'b0;
  logic [31:0] in_term_id = 32'd0;
  logic [31:0] in_doc_id = 32'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_term;
  logic [31:0] out_doc;
  logic        out_new_term;
  logic [2:0]  out_refill_stream;

  logic        slot_full [kmg_pkg::WAYS];
  logic        slot_done [kmg_pkg::WAYS];
  logic [31:0] slot_term [kmg_pkg::WAYS];
  logic [31:0] slot_doc [kmg_pkg::WAYS];
  logic [31:0] last_term = 32'd0;
  logic        seen_term = 1'b0;
  logic [3:0]  streams_cfg = 4'd8;

  kmg_pkg::res_t pending_results [$];
  kmg_pkg::res_t seen_res;
  kmg_pkg::res_t want_res;
  int          fail_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  logic [31:0] key_base = 32'd0;
  plan_row_t   plan [19];
  int          phase_cfg [5] = '{5, 8, 4, 12, 15};
  int          in_mode [4] = '{0, 50, 0, 27};
  int          out_mode [4] = '{0, 0, 50, 27};

  kway_record_merge_grouper_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_index  (in_stream_index),
    .in_end_of_stream (in_end_of_stream),
    .in_term_id       (in_term_id),
    .in_doc_id        (in_doc_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_term         (out_term),
    .out_doc          (out_doc),
    .out_new_term     (out_new_term),
    .out_refill_stream(out_refill_stream)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int live_runs();
    int n;
    n = streams_cfg;
    if (n < 1) n = 1;
    if (n > kmg_pkg::WAYS) n = kmg_pkg::WAYS;
    return n;
  endfunction

  function automatic logic merge_complete();
    int n;
    n = live_runs();
    for (int i = 0; i < n; i++) begin
      if (slot_full[i] || !slot_done[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic merge_predict(input logic [2:0] s, input logic e,
                                         input logic [31:0] t, input logic [31:0] d,
                                         output kmg_pkg::res_t r);
    int   n;
    int   best;
    logic found;
    n = live_runs();
    best = 0;
    found = 1'b0;
    r = NO_RES;
    if (s >= n || slot_full[s] || slot_done[s]) begin
      r.status = kmg_pkg::ST_ERROR;
      return 1'b1;
    end
    if (e) begin
      slot_done[s] = 1'b1;
    end else begin
      slot_full[s] = 1'b1;
      slot_term[s] = t;
      slot_doc[s] = d;
    end
    for (int i = 0; i < n; i++) begin
      if (!slot_full[i] && !slot_done[i]) return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (slot_full[i] && (!found || slot_term[i] < slot_term[best] ||
          (slot_term[i] == slot_term[best] && slot_doc[i] < slot_doc[best]))) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.status = kmg_pkg::ST_DONE;
      return 1'b1;
    end
    r.status = kmg_pkg::ST_RECORD;
    r.term = slot_term[best];
    r.doc = slot_doc[best];
    r.new_term = !seen_term || slot_term[best] != last_term;
    r.refill = 3'(best);
    last_term = slot_term[best];
    seen_term = 1'b1;
    slot_full[best] = 1'b0;
    return 1'b1;
  endfunction

  task automatic put_record(input logic [2:0] s, input logic e, input logic [31:0] t,
                            input logic [31:0] d, input logic typed, input logic has_res,
                            input kmg_pkg::res_t want);
    kmg_pkg::res_t r;
    logic          got;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_index <= s;
    in_end_of_stream <= e;
    in_term_id <= t;
    in_doc_id <= d;
    do @(posedge clk); while (!in_ready);
    got = merge_predict(s, e, t, d, r);
    if (typed) begin
      if (has_res) pending_results = {pending_results, want};
    end else if (got) begin
      pending_results = {pending_results, r};
    end
  endtask

  task automatic write_streams(input logic [3:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    streams_cfg = v;
  endtask

  task automatic random_item(input logic ending);
    int          open_q [$];
    int          n;
    logic [2:0]  s;
    logic        e;
    logic [31:0] t;
    logic [31:0] d;
    n = live_runs();
    for (int i = 0; i < n; i++) begin
      if (!slot_full[i] && !slot_done[i]) open_q = {open_q, i};
    end
    t = ($urandom_range(0, 15) == 0) ? $urandom : key_base + $urandom_range(0, 3);
    d = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
    if (open_q.size() == 0 || (!ending && $urandom_range(0, 99) < 6)) begin
      s = 3'($urandom_range(0, 7));
      e = ($urandom_range(0, 15) == 0);
    end else begin
      s = 3'(open_q[$urandom_range(0, open_q.size() - 1)]);
      e = ending || ($urandom_range(0, 399) == 0);
    end
    put_record(s, e, t, d, 1'b0, 1'b0, NO_RES);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_res = '{out_status, out_term, out_doc, out_new_term, out_refill_stream};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d term %h doc %h new %0b refill %0d",
                   seen_res.status, seen_res.term, seen_res.doc, seen_res.new_term,
                   seen_res.refill);
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res !== want_res) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch want %0d %h %h %0b %0d got %0d %h %h %0b %0d",
                     want_res.status, want_res.term, want_res.doc, want_res.new_term,
                     want_res.refill, seen_res.status, seen_res.term, seen_res.doc,
                     seen_res.new_term, seen_res.refill);
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  initial begin
    for (int i = 0; i < kmg_pkg::WAYS; i++) begin
      slot_full[i] = 1'b0;
      slot_done[i] = 1'b0;
      slot_term[i] = 32'd0;
      slot_doc[i] = 32'd0;
    end
    plan = '{
      '{1'b1, 4'd0, 3'd0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1, ERR_RES},
      '{1'b0, 4'd0, 3'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd0}},
      '{1'b0, 4'd0, 3'd0, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'hFFFF_FFFF, 32'h0, 1'b0, 3'd0}},
      '{1'b0, 4'd0, 3'd0, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'h0, 32'h0, 1'b1, 3'd0}},
      '{1'b0, 4'd0, 3'd0, 1'b1, 32'h0, 32'h0, 1'b1, 1'b1, DONE_RES},
      '{1'b0, 4'd0, 3'd0, 1'b0, 32'h1, 32'h1, 1'b1, 1'b1, ERR_RES},
      '{1'b0, 4'd0, 3'd7, 1'b1, 32'h0, 32'h0, 1'b1, 1'b1, ERR_RES},
      '{1'b1, 4'd3, 3'd0, 1'b0, 32'h0, 32'h0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'h5, 32'h9, 1'b1, 1'b0, NO_RES},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'h1, 32'h1, 1'b1, 1'b1, ERR_RES},
      '{1'b0, 4'd0, 3'd3, 1'b0, 32'h0, 32'h0, 1'b1, 1'b1, ERR_RES},
      '{1'b0, 4'd0, 3'd2, 1'b0, 32'h5, 32'h9, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'h5, 32'h9, 1'b1, 3'd1}},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'h5, 32'h9, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'h5, 32'h9, 1'b0, 3'd1}},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'h5, 32'h8, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'h5, 32'h8, 1'b0, 3'd1}},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'h4, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{kmg_pkg::ST_RECORD, 32'h4, 32'hFFFF_FFFF, 1'b1, 3'd1}},
      '{1'b0, 4'd0, 3'd1, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, NO_RES},
      '{1'b0, 4'd0, 3'd2, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_RES},
      '{1'b0, 4'd0, 3'd0, 1'b1, 32'h0, 32'h0, 1'b1, 1'b1, ERR_RES}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        write_streams(plan[k].cfg_val);
      end else begin
        put_record(plan[k].run, plan[k].eos, plan[k].term, plan[k].doc,
                   plan[k].typed, plan[k].has_res, plan[k].want);
      end
    end
    for (int p = 0; p < 5; p++) begin
      write_streams(4'(phase_cfg[p]));
      in_idle_pct = in_mode[p % 4];
      out_stall_pct = out_mode[p % 4];
      key_base = $urandom;
      repeat (105) random_item(1'b0);
    end
    in_idle_pct = 27;
    out_stall_pct = 27;
    for (int k = 0; k < 40 && !merge_complete(); k++) random_item(1'b1);
    repeat (3) random_item(1'b0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
